FILE: rtl/kttc_pkg.sv
// ----------------------------------------------------------------------------
// kttc_pkg
// Shared types, dictionary words and per-family size data for the key-type
// token classifier.
// ----------------------------------------------------------------------------
package kttc_pkg;

    // Longest dictionary word is the generic DER role word.
    localparam int WORD_MAX_LEN = 11;
    localparam int WORD_IDX_W   = $clog2(WORD_MAX_LEN);
    localparam int WORD_LEN_W   = $clog2(WORD_MAX_LEN + 1);

    localparam int NUM_MODE  = 2;
    localparam int NUM_ROLE  = 4;
    localparam int NUM_FAM   = 25;
    localparam int NUM_WORDS = NUM_MODE + NUM_ROLE + NUM_FAM;

    localparam logic [7:0] COMMA_CHAR = 8'd44;
    localparam logic [7:0] END_CHAR   = 8'd0;

    // Role flag bit positions.
    localparam int ROLE_ATT     = 0;
    localparam int ROLE_PKEY    = 1;
    localparam int ROLE_CERT    = 2;
    localparam int ROLE_GEN_DER = 3;

    localparam logic [4:0] FAM_NONE    = 5'd0;
    localparam logic [4:0] FAM_CERT    = 5'd24;
    localparam logic [4:0] FAM_DER_KEY = 5'd25;

    typedef logic [WORD_MAX_LEN-1:0][7:0] token_chars_t;

    typedef struct packed {
        logic [8*WORD_MAX_LEN-1:0] text;  // last character in the low byte
        logic [WORD_LEN_W-1:0]     len;
    } dict_entry_t;

    typedef struct packed {
        logic [NUM_MODE-1:0] mode_hit;
        logic [NUM_ROLE-1:0] role_hit;
        logic [4:0]          family;
    } match_t;

    typedef struct packed {
        logic [11:0] pk_bytes;
        logic [12:0] sig_bytes;
        logic        sig_der;
    } fam_info_t;

    // Mode words, then role words, then family words in code order.
    localparam dict_entry_t DICT [NUM_WORDS] = '{
        '{text: "ExDSA",       len: 4'd5},
        '{text: "ECDH",        len: 4'd4},
        '{text: "ATT",         len: 4'd3},
        '{text: "PKEY",        len: 4'd4},
        '{text: "CERT",        len: 4'd4},
        '{text: "GENERIC_DER", len: 4'd11},
        '{text: "SECP256R1",   len: 4'd9},
        '{text: "SECP384R1",   len: 4'd9},
        '{text: "SECP521R1",   len: 4'd9},
        '{text: "SECP256K1",   len: 4'd9},
        '{text: "ED25519",     len: 4'd7},
        '{text: "ED448",       len: 4'd5},
        '{text: "CURVE25519",  len: 4'd10},
        '{text: "CURVE448",    len: 4'd8},
        '{text: "AES128",      len: 4'd6},
        '{text: "AES192",      len: 4'd6},
        '{text: "AES256",      len: 4'd6},
        '{text: "SHA2-256",    len: 4'd8},
        '{text: "SHA2-384",    len: 4'd8},
        '{text: "SHA2-512",    len: 4'd8},
        '{text: "SHA3-256",    len: 4'd8},
        '{text: "SHA3-384",    len: 4'd8},
        '{text: "SHA3-512",    len: 4'd8},
        '{text: "MLKEM512",    len: 4'd8},
        '{text: "MLKEM768",    len: 4'd8},
        '{text: "MLKEM1024",   len: 4'd9},
        '{text: "MLDSA44",     len: 4'd7},
        '{text: "MLDSA65",     len: 4'd7},
        '{text: "MLDSA87",     len: 4'd7},
        '{text: "CERT",        len: 4'd4},
        '{text: "DER_PKEY",    len: 4'd8}
    };

    // Entry i describes family code i + 1.
    localparam fam_info_t FAM_INFO [NUM_FAM] = '{
        '{12'd33,   13'd72,   1'b1},
        '{12'd49,   13'd104,  1'b1},
        '{12'd67,   13'd141,  1'b1},
        '{12'd33,   13'd72,   1'b1},
        '{12'd32,   13'd64,   1'b0},
        '{12'd57,   13'd114,  1'b0},
        '{12'd32,   13'd0,    1'b0},
        '{12'd56,   13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd800,  13'd0,    1'b0},
        '{12'd1184, 13'd0,    1'b0},
        '{12'd1568, 13'd0,    1'b0},
        '{12'd1312, 13'd2420, 1'b0},
        '{12'd1952, 13'd3309, 1'b0},
        '{12'd2592, 13'd4627, 1'b0},
        '{12'd0,    13'd0,    1'b0},
        '{12'd0,    13'd0,    1'b0}
    };

endpackage

FILE: rtl/kttc_word_match.sv
// ----------------------------------------------------------------------------
// kttc_word_match
// Compares the stored token against every dictionary word in parallel and
// reports the mode hit, the role hit or the first family hit.
// ----------------------------------------------------------------------------
module kttc_word_match (
    input  kttc_pkg::token_chars_t                tok_chars,
    input  logic [kttc_pkg::WORD_LEN_W-1:0]       tok_len,
    input  logic                                  tok_valid,
    output kttc_pkg::match_t                      result
);

    logic [kttc_pkg::NUM_WORDS-1:0] hit;
    logic                           mode_any;
    logic                           role_any;
    logic [4:0]                     fam_first;

    always_comb
    begin
        for (int w = 0; w < kttc_pkg::NUM_WORDS; w++)
        begin
            hit[w] = tok_valid && (tok_len == kttc_pkg::DICT[w].len);
            for (int i = 0; i < kttc_pkg::WORD_MAX_LEN; i++)
            begin
                if (i < int'(kttc_pkg::DICT[w].len))
                begin
                    hit[w] = hit[w] && (tok_chars[i] ==
                        kttc_pkg::DICT[w].text[8*(int'(kttc_pkg::DICT[w].len) - 1 - i) +: 8]);
                end
            end
        end
    end

    // Family words are distinct, so at most one family entry hits; the scan still keeps
    // the lowest family index.
    always_comb
    begin
        fam_first = kttc_pkg::FAM_NONE;
        for (int f = kttc_pkg::NUM_FAM - 1; f >= 0; f--)
        begin
            if (hit[kttc_pkg::NUM_MODE + kttc_pkg::NUM_ROLE + f])
            begin
                fam_first = 5'(f + 1);
            end
        end
    end

    assign mode_any = |hit[kttc_pkg::NUM_MODE-1:0];
    assign role_any = |hit[kttc_pkg::NUM_MODE +: kttc_pkg::NUM_ROLE];

    assign result.mode_hit = hit[kttc_pkg::NUM_MODE-1:0];
    assign result.role_hit = mode_any ? '0 : hit[kttc_pkg::NUM_MODE +: kttc_pkg::NUM_ROLE];
    assign result.family   = (mode_any || role_any) ? kttc_pkg::FAM_NONE : fam_first;

endmodule

FILE: rtl/kttc_family_info.sv
// ----------------------------------------------------------------------------
// kttc_family_info
// Looks up public key size, maximum signature size and DER flag of a family.
// ----------------------------------------------------------------------------
module kttc_family_info (
    input  logic [4:0]          family,
    output kttc_pkg::fam_info_t info
);

    logic [4:0] idx;

    assign idx = family - 5'd1;

    always_comb
    begin
        if (family != kttc_pkg::FAM_NONE && family <= 5'(kttc_pkg::NUM_FAM))
        begin
            info = kttc_pkg::FAM_INFO[idx];
        end
        else
        begin
            info = '0;
        end
    end

endmodule

FILE: rtl/key_type_token_classifier.sv
// ----------------------------------------------------------------------------
// key_type_token_classifier
// Splits a key-type string into comma-separated tokens and classifies them.
// ----------------------------------------------------------------------------
// Usage: the sender drives one string byte per item on char_byte with
// in_valid. Commas separate tokens and a zero byte ends the string. Only the
// ending byte produces a result item on the output channel, carrying the
// family code, the mode and role flags and the family's size data.
// Path: an accepted byte is first held in the input register; the result of an
// ending byte is then captured in the result register that drives the outputs.
// One byte is accepted every cycle while in_stall is low, set by the single
// pass from the input register through the token compare to the result register.
// While a result waits under out_stall, ordinary bytes still flow; only a
// second ending byte holds in the input register and raises in_stall.
// Reset clears the token length, overflow mark, family and flags and empties
// both registers; the token character store is written before it is read.
// After each result the token state returns to its reset value.
// ----------------------------------------------------------------------------
module key_type_token_classifier #(
    parameter int MAX_TOKEN_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  family_code,
    output logic        mode_exdsa,
    output logic        mode_ecdh,
    output logic        role_att,
    output logic        role_pkey,
    output logic        role_cert,
    output logic        role_gen_der,
    output logic [11:0] public_key_bytes,
    output logic [12:0] signature_max_bytes,
    output logic        signature_is_der
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

    // Input register
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg, in_byte_next;

    // Token and string state
    kttc_pkg::token_chars_t chars_reg, chars_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [4:0]            fam_reg, fam_next;
    logic [kttc_pkg::NUM_MODE-1:0] mode_reg, mode_next;
    logic [kttc_pkg::NUM_ROLE-1:0] role_reg, role_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [4:0]            res_fam_reg, res_fam_next;
    logic [kttc_pkg::NUM_MODE-1:0] res_mode_reg, res_mode_next;
    logic [kttc_pkg::NUM_ROLE-1:0] res_role_reg, res_role_next;
    kttc_pkg::fam_info_t   res_info_reg, res_info_next;

    logic                  in_accept;
    logic                  is_end;
    logic                  is_comma;
    logic                  step_go;
    logic                  step;
    logic                  tok_valid;
    kttc_pkg::match_t      match;
    logic [kttc_pkg::NUM_MODE-1:0] mode_close;
    logic [kttc_pkg::NUM_ROLE-1:0] role_close;
    logic [4:0]            fam_close;
    logic [4:0]            fam_resolved;
    kttc_pkg::fam_info_t   fam_info;

    assign is_end   = (in_byte_reg == kttc_pkg::END_CHAR);
    assign is_comma = (in_byte_reg == kttc_pkg::COMMA_CHAR);

    // An ending byte must wait while the previous result is still held.
    assign step_go   = !(is_end && out_valid_reg && out_stall);
    assign step      = in_valid_reg && step_go;
    assign in_stall  = in_valid_reg && !step_go;
    assign in_accept = in_valid && !in_stall;

    // Only tokens no longer than the longest word can match anything.
    assign tok_valid = !ovf_reg && (len_reg <= CNT_W'(kttc_pkg::WORD_MAX_LEN));

    kttc_word_match u_match (
        .tok_chars (chars_reg),
        .tok_len   (kttc_pkg::WORD_LEN_W'(len_reg)),
        .tok_valid (tok_valid),
        .result    (match)
    );

    assign mode_close = mode_reg | match.mode_hit;
    assign role_close = role_reg | match.role_hit;
    assign fam_close  = (fam_reg != kttc_pkg::FAM_NONE) ? fam_reg : match.family;

    always_comb
    begin
        priority if (fam_close != kttc_pkg::FAM_NONE)
        begin
            fam_resolved = fam_close;
        end
        else if (role_close[kttc_pkg::ROLE_CERT])
        begin
            fam_resolved = kttc_pkg::FAM_CERT;
        end
        else if (role_close[kttc_pkg::ROLE_GEN_DER])
        begin
            fam_resolved = kttc_pkg::FAM_DER_KEY;
        end
        else
        begin
            fam_resolved = kttc_pkg::FAM_NONE;
        end
    end

    kttc_family_info u_info (
        .family (fam_resolved),
        .info   (fam_info)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        chars_next     = chars_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        fam_next       = fam_reg;
        mode_next      = mode_reg;
        role_next      = role_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_fam_next   = res_fam_reg;
        res_mode_next  = res_mode_reg;
        res_role_next  = res_role_reg;
        res_info_next  = res_info_reg;

        if (step)
        begin
            in_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = char_byte;
        end

        if (step)
        begin
            if (is_end)
            begin
                out_valid_next = 1'b1;
                res_fam_next   = fam_resolved;
                res_mode_next  = mode_close;
                res_role_next  = role_close;
                res_info_next  = fam_info;
                len_next       = '0;
                ovf_next       = 1'b0;
                fam_next       = kttc_pkg::FAM_NONE;
                mode_next      = '0;
                role_next      = '0;
            end
            else if (is_comma)
            begin
                len_next  = '0;
                ovf_next  = 1'b0;
                fam_next  = fam_close;
                mode_next = mode_close;
                role_next = role_close;
            end
            else if (len_reg < CNT_W'(MAX_TOKEN_LEN))
            begin
                // Bytes past the longest word only need counting.
                if (len_reg < CNT_W'(kttc_pkg::WORD_MAX_LEN))
                begin
                    chars_next[len_reg[kttc_pkg::WORD_IDX_W-1:0]] = in_byte_reg;
                end
                len_next = len_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            fam_reg       <= kttc_pkg::FAM_NONE;
            mode_reg      <= '0;
            role_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            fam_reg       <= fam_next;
            mode_reg      <= mode_next;
            role_reg      <= role_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        chars_reg    <= chars_next;
        res_fam_reg  <= res_fam_next;
        res_mode_reg <= res_mode_next;
        res_role_reg <= res_role_next;
        res_info_reg <= res_info_next;
    end

    assign out_valid           = out_valid_reg;
    assign family_code         = res_fam_reg;
    assign mode_exdsa          = res_mode_reg[0];
    assign mode_ecdh           = res_mode_reg[1];
    assign role_att            = res_role_reg[kttc_pkg::ROLE_ATT];
    assign role_pkey           = res_role_reg[kttc_pkg::ROLE_PKEY];
    assign role_cert           = res_role_reg[kttc_pkg::ROLE_CERT];
    assign role_gen_der        = res_role_reg[kttc_pkg::ROLE_GEN_DER];
    assign public_key_bytes    = res_info_reg.pk_bytes;
    assign signature_max_bytes = res_info_reg.sig_bytes;
    assign signature_is_der    = res_info_reg.sig_der;

`ifndef ASSERT_OFF
    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_end) |=> (out_valid_reg && len_reg == '0 && !ovf_reg
            && fam_reg == kttc_pkg::FAM_NONE && mode_reg == '0 && role_reg == '0))
        else $error("token state not cleared after string end");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(MAX_TOKEN_LEN))
        else $error("token length above limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == CNT_W'(MAX_TOKEN_LEN)))
        else $error("overflow marked on a token that is not full");

    a_fam_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (family_code <= 5'(kttc_pkg::NUM_FAM)))
        else $error("family code out of range");

    a_der_family: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && signature_is_der) |->
            (family_code >= 5'd1 && family_code <= 5'd4))
        else $error("DER signature flag on a non-ECDSA family");
`endif

endmodule

FILE: tb/sv/key_type_token_classifier_tb.sv
// ----------------------------------------------------------------------------
// key_type_token_classifier_tb
// Self-checking testbench for the key-type token classifier. Strings are fed
// one byte per item: first a table of directed strings, then a phase that
// holds off the result side to back the block up, then random strings. Each
// accepted byte goes through a behavioral classifier in the bench, and each
// result item is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module key_type_token_classifier_tb;

    localparam int TOKEN_DEPTH   = 16;
    localparam int TOTAL_ITEMS   = 900;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 16;
    localparam int MODE_EXDSA    = 0;
    localparam int MODE_ECDH     = 1;

    localparam logic [4:0] FAM_SECP521R1 = 5'd3;
    localparam logic [4:0] FAM_MLDSA87   = 5'd23;

    typedef struct packed {
        logic [4:0]  fam;
        logic        exdsa;
        logic        ecdh;
        logic        att;
        logic        pkey;
        logic        cert;
        logic        gder;
        logic [11:0] pk;
        logic [12:0] sig;
        logic        der;
    } class_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  family_code;
    logic        mode_exdsa;
    logic        mode_ecdh;
    logic        role_att;
    logic        role_pkey;
    logic        role_cert;
    logic        role_gen_der;
    logic [11:0] public_key_bytes;
    logic [12:0] signature_max_bytes;
    logic        signature_is_der;

    key_type_token_classifier u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .char_byte           (char_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .family_code         (family_code),
        .mode_exdsa          (mode_exdsa),
        .mode_ecdh           (mode_ecdh),
        .role_att            (role_att),
        .role_pkey           (role_pkey),
        .role_cert           (role_cert),
        .role_gen_der        (role_gen_der),
        .public_key_bytes    (public_key_bytes),
        .signature_max_bytes (signature_max_bytes),
        .signature_is_der    (signature_is_der)
    );

    // Dictionary and per-family sizes, family code = index + 1.
    string mode_words [2] = '{"ExDSA", "ECDH"};
    string role_words [4] = '{"ATT", "PKEY", "CERT", "GENERIC_DER"};
    string family_words [25] = '{
        "SECP256R1", "SECP384R1", "SECP521R1", "SECP256K1", "ED25519",
        "ED448", "CURVE25519", "CURVE448", "AES128", "AES192", "AES256",
        "SHA2-256", "SHA2-384", "SHA2-512", "SHA3-256", "SHA3-384",
        "SHA3-512", "MLKEM512", "MLKEM768", "MLKEM1024", "MLDSA44",
        "MLDSA65", "MLDSA87", "CERT", "DER_PKEY"
    };
    int family_pk [25] = '{
        33, 49, 67, 33, 32, 57, 32, 56, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        800, 1184, 1568, 1312, 1952, 2592, 0, 0
    };
    int family_sig [25] = '{
        72, 104, 141, 72, 64, 114, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 2420, 3309, 4627, 0, 0
    };
    bit family_der [25] = '{
        1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // Classifier state.
    logic [7:0] tok_buf [TOKEN_DEPTH];
    int         tok_len    = 0;
    bit         tok_ovf    = 1'b0;
    logic [4:0] fam_kept   = kttc_pkg::FAM_NONE;
    logic [1:0] modes_seen = '0;
    logic [3:0] roles_seen = '0;

    class_result_t expected_results [$];
    logic [7:0]    pending_bytes [$];

    string         dir_text  [$];
    bit            dir_typed [$];
    class_result_t dir_exp   [$];

    int            fail_count   = 0;
    int            items_sent   = 0;
    int            hold_id      = 0;
    int            hold_seen    = 0;
    int            stall_left   = 0;
    bit            quiet        = 1'b0;
    class_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("%0t: run did not finish in time", $time);
        $display("[key_type_token_classifier] ERROR");
        $finish;
    end

    function automatic bit token_is(string w);
        int i;
        begin
            if (tok_ovf || w.len() != tok_len)
                return 1'b0;
            for (i = 0; i < tok_len; i++)
                if (tok_buf[i] != w[i])
                    return 1'b0;
            return 1'b1;
        end
    endfunction

    // Mode words win over role words, role words over the family table, and
    // only the first family word of a string is kept.
    task automatic close_token();
        bit hit;
        int i;
        begin
            hit = 1'b0;
            for (i = 0; i < 2; i++)
                if (!hit && token_is(mode_words[i]))
                begin
                    modes_seen[i] = 1'b1;
                    hit = 1'b1;
                end
            for (i = 0; i < 4; i++)
                if (!hit && token_is(role_words[i]))
                begin
                    roles_seen[i] = 1'b1;
                    hit = 1'b1;
                end
            if (!hit)
                for (i = 0; i < 25; i++)
                    if (fam_kept == kttc_pkg::FAM_NONE && token_is(family_words[i]))
                        fam_kept = 5'(i + 1);
            tok_len = 0;
            tok_ovf = 1'b0;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, output bit emitted,
                                 output class_result_t res);
        logic [4:0] fam;
        begin
            emitted = 1'b0;
            res     = '0;
            if (b == kttc_pkg::COMMA_CHAR)
                close_token();
            else if (b != kttc_pkg::END_CHAR)
            begin
                if (tok_len < TOKEN_DEPTH)
                begin
                    tok_buf[tok_len] = b;
                    tok_len++;
                end
                else
                    tok_ovf = 1'b1;
            end
            else
            begin
                close_token();
                fam = fam_kept;
                if (fam == kttc_pkg::FAM_NONE)
                begin
                    if (roles_seen[kttc_pkg::ROLE_CERT])
                        fam = kttc_pkg::FAM_CERT;
                    else if (roles_seen[kttc_pkg::ROLE_GEN_DER])
                        fam = kttc_pkg::FAM_DER_KEY;
                end
                res.fam   = fam;
                res.exdsa = modes_seen[MODE_EXDSA];
                res.ecdh  = modes_seen[MODE_ECDH];
                res.att   = roles_seen[kttc_pkg::ROLE_ATT];
                res.pkey  = roles_seen[kttc_pkg::ROLE_PKEY];
                res.cert  = roles_seen[kttc_pkg::ROLE_CERT];
                res.gder  = roles_seen[kttc_pkg::ROLE_GEN_DER];
                if (fam != kttc_pkg::FAM_NONE)
                begin
                    res.pk  = 12'(family_pk[fam - 1]);
                    res.sig = 13'(family_sig[fam - 1]);
                    res.der = family_der[fam - 1];
                end
                emitted    = 1'b1;
                fam_kept   = kttc_pkg::FAM_NONE;
                modes_seen = '0;
                roles_seen = '0;
            end
        end
    endtask

    function automatic class_result_t make_result(logic [4:0] fam, logic [1:0] modes,
                                                  logic [3:0] roles, int pk, int sig,
                                                  bit der);
        class_result_t r;
        begin
            r.fam   = fam;
            r.exdsa = modes[MODE_EXDSA];
            r.ecdh  = modes[MODE_ECDH];
            r.att   = roles[kttc_pkg::ROLE_ATT];
            r.pkey  = roles[kttc_pkg::ROLE_PKEY];
            r.cert  = roles[kttc_pkg::ROLE_CERT];
            r.gder  = roles[kttc_pkg::ROLE_GEN_DER];
            r.pk    = 12'(pk);
            r.sig   = 13'(sig);
            r.der   = der;
            return r;
        end
    endfunction

    task automatic add_row(string text, bit typed, class_result_t exp);
        begin
            dir_text.push_back(text);
            dir_typed.push_back(typed);
            dir_exp.push_back(exp);
        end
    endtask

    function automatic string dict_word(int idx);
        begin
            if (idx < 2)
                return mode_words[idx];
            if (idx < 6)
                return role_words[idx - 2];
            return family_words[idx - 6];
        end
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == kttc_pkg::COMMA_CHAR);
            return b;
        end
    endfunction

    // Mostly well-formed strings of dictionary words with some damaged,
    // empty and over-long tokens; the rest is raw noise.
    task automatic build_random();
        int    ntok;
        int    t;
        int    i;
        int    n;
        int    kind;
        int    sel;
        string w;
        begin
            pending_bytes = {};
            if ($urandom_range(0, 99) < 85)
            begin
                ntok = $urandom_range(1, 4);
                for (t = 0; t < ntok; t++)
                begin
                    if (t != 0)
                        pending_bytes.push_back(kttc_pkg::COMMA_CHAR);
                    kind = $urandom_range(0, 9);
                    if (kind <= 6)
                    begin
                        w = dict_word($urandom_range(0, 30));
                        if (kind == 6)
                        begin
                            sel = $urandom_range(0, 2);
                            if (sel == 0)
                            begin
                                n = $urandom_range(0, w.len() - 1);
                                w[n] = w[n] ^ 8'h20;
                            end
                            else if (sel == 1)
                                w = w.substr(0, w.len() - 2);
                        end
                        for (i = 0; i < w.len(); i++)
                            pending_bytes.push_back(w[i]);
                        if (kind == 6 && sel == 2)
                            pending_bytes.push_back(token_byte());
                    end
                    else if (kind == 7)
                    begin
                        n = $urandom_range(1, 8);
                        for (i = 0; i < n; i++)
                            pending_bytes.push_back(token_byte());
                    end
                    else if (kind == 9)
                    begin
                        n = $urandom_range(TOKEN_DEPTH + 1, TOKEN_DEPTH + 8);
                        for (i = 0; i < n; i++)
                            pending_bytes.push_back(token_byte());
                    end
                end
            end
            else
            begin
                n = $urandom_range(1, 30);
                for (i = 0; i < n; i++)
                begin
                    sel = $urandom_range(0, 15);
                    if (sel == 0)
                        pending_bytes.push_back(kttc_pkg::COMMA_CHAR);
                    else if (sel == 1)
                        pending_bytes.push_back(kttc_pkg::END_CHAR);
                    else
                        pending_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            pending_bytes.push_back(kttc_pkg::END_CHAR);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input class_result_t typed_res);
        bit            emitted;
        class_result_t predicted;
        begin
            in_valid  <= 1'b1;
            char_byte <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
            classify_byte(b, emitted, predicted);
            if (emitted)
                expected_results.push_back(typed ? typed_res : predicted);
        end
    endtask

    task automatic send_sequence(input bit gaps, input bit typed, input class_result_t exp);
        int i;
        begin
            for (i = 0; i < pending_bytes.size(); i++)
            begin
                send_byte(pending_bytes[i], typed && (i == pending_bytes.size() - 1), exp);
                if (gaps && !quiet && $urandom_range(0, 7) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 16))
                        @(posedge clk);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [12:0] exp_val,
                               input logic [12:0] got_val);
        begin
            if (got_val !== exp_val)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, got_val);
                fail_count++;
            end
        end
    endtask

    // Result side: check accepted items, then choose the stall for the next
    // cycle. A long hold is requested by bumping hold_id.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result item with none expected, family_code %0d",
                             $time, family_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("family_code", 13'(want.fam), 13'(family_code));
                    check_field("mode_exdsa", 13'(want.exdsa), 13'(mode_exdsa));
                    check_field("mode_ecdh", 13'(want.ecdh), 13'(mode_ecdh));
                    check_field("role_att", 13'(want.att), 13'(role_att));
                    check_field("role_pkey", 13'(want.pkey), 13'(role_pkey));
                    check_field("role_cert", 13'(want.cert), 13'(role_cert));
                    check_field("role_gen_der", 13'(want.gder), 13'(role_gen_der));
                    check_field("public_key_bytes", 13'(want.pk), 13'(public_key_bytes));
                    check_field("signature_max_bytes", want.sig, signature_max_bytes);
                    check_field("signature_is_der", 13'(want.der), 13'(signature_is_der));
                end
            end
            if (hold_seen != hold_id)
            begin
                hold_seen  = hold_id;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 15);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int r;
        int i;
        int k;
        int drain;

        add_row("", 1'b1, make_result(kttc_pkg::FAM_NONE, 2'b00, 4'b0000, 0, 0, 1'b0));
        add_row("MLDSA87", 1'b1, make_result(FAM_MLDSA87, 2'b00, 4'b0000, 2592, 4627, 1'b0));
        add_row("SECP521R1,ExDSA", 1'b1,
                make_result(FAM_SECP521R1, 2'(1 << MODE_EXDSA), 4'b0000, 67, 141, 1'b1));
        add_row("CERT", 1'b1,
                make_result(kttc_pkg::FAM_CERT, 2'b00, 4'(1 << kttc_pkg::ROLE_CERT),
                            0, 0, 1'b0));
        add_row("GENERIC_DER", 1'b1,
                make_result(kttc_pkg::FAM_DER_KEY, 2'b00,
                            4'(1 << kttc_pkg::ROLE_GEN_DER), 0, 0, 1'b0));
        add_row("ExDSA,ECDH,ATT,PKEY", 1'b1,
                make_result(kttc_pkg::FAM_NONE, 2'b11,
                            4'((1 << kttc_pkg::ROLE_ATT) | (1 << kttc_pkg::ROLE_PKEY)),
                            0, 0, 1'b0));
        add_row(",,ED25519,,", 1'b0, '0);
        add_row("ED448,MLDSA87", 1'b0, '0);
        add_row("ecdh,Ed25519,AES", 1'b0, '0);
        add_row("ABCDEFGHIJKLMNOP,ABCDEFGHIJKLMNOPQRST,CURVE448", 1'b0, '0);
        add_row("\200\377,SHA3-512", 1'b0, '0);
        add_row("CERT,GENERIC_DER,MLKEM1024", 1'b0, '0);
        add_row("GENERIC_DER,SECP256K1XXXXXXXXXXXXX,CERT", 1'b0, '0);

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < dir_text.size(); r++)
        begin
            pending_bytes = {};
            for (i = 0; i < dir_text[r].len(); i++)
                pending_bytes.push_back(dir_text[r][i]);
            pending_bytes.push_back(kttc_pkg::END_CHAR);
            send_sequence(1'b1, dir_typed[r], dir_exp[r]);
        end

        // Hold off the result side while short strings keep coming, so that
        // a second ending byte backs up into the input.
        hold_id <= hold_id + 1;
        for (k = 0; k < 24; k++)
        begin
            if (k % 2 == 0)
            begin
                pending_bytes = {};
                pending_bytes.push_back(kttc_pkg::END_CHAR);
            end
            else
                build_random();
            send_sequence(1'b0, 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (!quiet && items_sent > TOTAL_ITEMS * 85 / 100)
                quiet <= 1'b1;
            build_random();
            send_sequence(1'b1, 1'b0, '0);
        end
        in_valid <= 1'b0;

        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[key_type_token_classifier] OK");
        else
            $display("[key_type_token_classifier] ERROR");
        $finish;
    end

endmodule
